>>> rtl/core/cau_pkg.sv
// Shared constants, types and the saturation function of the complex arithmetic unit.
package cau_pkg;

   localparam int DATA_WIDTH    = 32;
   localparam int FRACTION_BITS = 16;

   localparam int PROD_WIDTH  = 2 * DATA_WIDTH;          // exact product of two parts
   localparam int SUM_WIDTH   = PROD_WIDTH + 1;          // sum of two products
   localparam int SAT_WIDTH   = SUM_WIDTH;               // widest value fed to saturation
   localparam int QUOT_BITS   = DATA_WIDTH + 1;          // quotient bits resolved per divide
   localparam int DIV_LATENCY = QUOT_BITS + 1;           // register stages inside the divider

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] value;
      logic                  ov;
   } sat_type;

   // Clamp a signed value to DATA_WIDTH bits.
   function automatic sat_type sat_fn(input logic signed [SAT_WIDTH-1:0] v);
      sat_type                       r;
      logic signed [SAT_WIDTH-1:0]   hi;
      logic signed [SAT_WIDTH-1:0]   lo;
      hi = SAT_WIDTH'({1'b0, {(DATA_WIDTH-1){1'b1}}});
      lo = -hi - SAT_WIDTH'(1);
      if (v > hi) begin
         r.value = hi[DATA_WIDTH-1:0];
         r.ov    = 1'b1;
      end else if (v < lo) begin
         r.value = lo[DATA_WIDTH-1:0];
         r.ov    = 1'b1;
      end else begin
         r.value = v[DATA_WIDTH-1:0];
         r.ov    = 1'b0;
      end
      return r;
   endfunction

endpackage

>>> rtl/core/cau_div.sv
// Pipelined restoring divider: one quotient bit per stage, saturated signed result.
module cau_div (
   input  logic                            clock,
   input  logic                            en,
   input  logic [cau_pkg::PROD_WIDTH-1:0]  num_mag,
   input  logic                            num_neg,
   input  logic [cau_pkg::PROD_WIDTH-1:0]  den,
   output logic [cau_pkg::DATA_WIDTH-1:0]  q_out,
   output logic                            ov_out
);
   import cau_pkg::*;

   localparam int NW = PROD_WIDTH + FRACTION_BITS;   // shifted numerator
   localparam int TW = NW - QUOT_BITS;               // bits above the quotient window
   localparam int RW = PROD_WIDTH + 1;               // partial remainder

   logic [RW-1:0]         r_ff   [QUOT_BITS+1];
   logic [QUOT_BITS-1:0]  low_ff [QUOT_BITS+1];
   logic [QUOT_BITS-1:0]  q_ff   [QUOT_BITS+1];
   logic [PROD_WIDTH-1:0] den_ff [QUOT_BITS+1];
   logic                  big_ff [QUOT_BITS+1];
   logic                  neg_ff [QUOT_BITS+1];

   logic [NW-1:0] num_in;
   logic [TW-1:0] top_in;
   logic          big_in;

   assign num_in = {num_mag, {FRACTION_BITS{1'b0}}} ;
   assign top_in = num_in[NW-1:QUOT_BITS];
   // quotient would need more bits than the window holds
   assign big_in = (NW'(top_in) >= NW'(den));

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]   <= RW'(top_in);
         low_ff[0] <= num_in[QUOT_BITS-1:0];
         q_ff[0]   <= '0;
         den_ff[0] <= den;
         big_ff[0] <= big_in;
         neg_ff[0] <= num_neg;
      end
   end

   for (genvar k = 1; k <= QUOT_BITS; k++) begin : g_step
      logic [RW-1:0] t_in;
      logic [RW-1:0] diff_in;
      logic          take_in;

      assign t_in    = {r_ff[k-1][RW-2:0], low_ff[k-1][QUOT_BITS-1]};
      assign take_in = (t_in >= RW'(den_ff[k-1]));
      assign diff_in = t_in - RW'(den_ff[k-1]);

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k]   <= take_in ? diff_in : t_in;
            low_ff[k] <= {low_ff[k-1][QUOT_BITS-2:0], 1'b0};
            q_ff[k]   <= {q_ff[k-1][QUOT_BITS-2:0], take_in};
            den_ff[k] <= den_ff[k-1];
            big_ff[k] <= big_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
      end
   end

   logic [QUOT_BITS-1:0] q_last;
   logic [QUOT_BITS-1:0] lim_pos;
   logic [QUOT_BITS-1:0] lim_neg;
   logic [QUOT_BITS-1:0] q_neg;

   assign q_last  = q_ff[QUOT_BITS];
   assign lim_pos = QUOT_BITS'({1'b0, {(DATA_WIDTH-1){1'b1}}});
   assign lim_neg = lim_pos + QUOT_BITS'(1);
   assign q_neg   = -q_last;

   always_comb begin
      if (!neg_ff[QUOT_BITS]) begin
         ov_out = big_ff[QUOT_BITS] || (q_last > lim_pos);
         q_out  = ov_out ? lim_pos[DATA_WIDTH-1:0] : q_last[DATA_WIDTH-1:0];
      end else begin
         ov_out = big_ff[QUOT_BITS] || (q_last > lim_neg);
         q_out  = ov_out ? lim_neg[DATA_WIDTH-1:0] : q_neg[DATA_WIDTH-1:0];
      end
   end

endmodule

>>> rtl/core/complex_arithmetic_unit_core.sv
// Top level of the complex arithmetic unit: add, subtract, multiply, divide in Q16.16.
//
//   channel   direction  ports
//   req       in         req_valid, req_ready, req_opcode, req_a_*, req_b_*
//   rsp       out        rsp_valid, rsp_ready, rsp_res_*, rsp_overflow, rsp_divide_by_zero
//
// One item enters per cycle while the output is not stalled; every item passes
// 4 + DIV_LATENCY + 1 register stages (39 at 32 bits). The depth is set by the divider,
// which resolves one quotient bit per stage. All opcodes pass the same stages so
// items leave in order. Reset clears the valid bits only.
// A stalled output register freezes the whole pipeline; req_ready falls with it.
module complex_arithmetic_unit_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_opcode,
   input  logic signed [cau_pkg::DATA_WIDTH-1:0] req_a_real,
   input  logic signed [cau_pkg::DATA_WIDTH-1:0] req_a_imag,
   input  logic signed [cau_pkg::DATA_WIDTH-1:0] req_b_real,
   input  logic signed [cau_pkg::DATA_WIDTH-1:0] req_b_imag,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [cau_pkg::DATA_WIDTH-1:0] rsp_res_real,
   output logic signed [cau_pkg::DATA_WIDTH-1:0] rsp_res_imag,
   output logic                                  rsp_overflow,
   output logic                                  rsp_divide_by_zero
);
   import cau_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int AW = DATA_WIDTH + 1;

   typedef struct packed {
      opcode_type      op;
      logic            dz;
      logic [W-1:0]    res_re;
      logic [W-1:0]    res_im;
      logic            ov;
   } side_type;

   logic en;

   // advance everything whenever the output register can take a new item
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // stage 1: capture operands
   logic                v1_ff;
   opcode_type          op1_ff;
   logic signed [W-1:0] ar1_ff, ai1_ff, br1_ff, bi1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op1_ff <= opcode_type'(req_opcode);
         ar1_ff <= req_a_real;
         ai1_ff <= req_a_imag;
         br1_ff <= req_b_real;
         bi1_ff <= req_b_imag;
      end
   end

   // stage 2: six exact products, plus the add/subtract sums
   logic                         v2_ff;
   opcode_type                   op2_ff;
   logic signed [PROD_WIDTH-1:0] p_rr2_ff, p_ii2_ff, p_ri2_ff, p_ir2_ff, p_bbr2_ff, p_bbi2_ff;
   logic signed [AW-1:0]         as_re2_ff, as_im2_ff;
   logic signed [AW-1:0]         as_re2_in, as_im2_in;

   always_comb begin
      if (op1_ff == OP_SUB) begin
         as_re2_in = AW'(ar1_ff) - AW'(br1_ff);
         as_im2_in = AW'(ai1_ff) - AW'(bi1_ff);
      end else begin
         as_re2_in = AW'(ar1_ff) + AW'(br1_ff);
         as_im2_in = AW'(ai1_ff) + AW'(bi1_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op2_ff    <= op1_ff;
         p_rr2_ff  <= PROD_WIDTH'(ar1_ff) * PROD_WIDTH'(br1_ff);
         p_ii2_ff  <= PROD_WIDTH'(ai1_ff) * PROD_WIDTH'(bi1_ff);
         p_ri2_ff  <= PROD_WIDTH'(ar1_ff) * PROD_WIDTH'(bi1_ff);
         p_ir2_ff  <= PROD_WIDTH'(ai1_ff) * PROD_WIDTH'(br1_ff);
         p_bbr2_ff <= PROD_WIDTH'(br1_ff) * PROD_WIDTH'(br1_ff);
         p_bbi2_ff <= PROD_WIDTH'(bi1_ff) * PROD_WIDTH'(bi1_ff);
         as_re2_ff <= as_re2_in;
         as_im2_ff <= as_im2_in;
      end
   end

   // stage 3: combine products; divisor is the squared magnitude of b
   logic                        v3_ff;
   opcode_type                  op3_ff;
   logic signed [SUM_WIDTH-1:0] mr3_ff, mi3_ff, nr3_ff, ni3_ff;
   logic [PROD_WIDTH-1:0]       den3_ff;
   logic signed [AW-1:0]        as_re3_ff, as_im3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op3_ff    <= op2_ff;
         mr3_ff    <= SUM_WIDTH'(p_rr2_ff) - SUM_WIDTH'(p_ii2_ff);
         mi3_ff    <= SUM_WIDTH'(p_ri2_ff) + SUM_WIDTH'(p_ir2_ff);
         nr3_ff    <= SUM_WIDTH'(p_rr2_ff) + SUM_WIDTH'(p_ii2_ff);
         ni3_ff    <= SUM_WIDTH'(p_ir2_ff) - SUM_WIDTH'(p_ri2_ff);
         den3_ff   <= p_bbr2_ff + p_bbi2_ff;
         as_re3_ff <= as_re2_ff;
         as_im3_ff <= as_im2_ff;
      end
   end

   // stage 4: finish add, subtract and multiply; split divide numerators into sign and size
   logic                    v4_ff;
   side_type                side4_ff;
   logic [PROD_WIDTH-1:0]   nr_mag4_ff, ni_mag4_ff, den4_ff;
   logic                    nr_neg4_ff, ni_neg4_ff;
   side_type                side4_in;
   sat_type                 sat_re, sat_im;
   logic signed [SUM_WIDTH-1:0] nr_abs, ni_abs;

   always_comb begin
      if (op3_ff == OP_MUL) begin
         sat_re = sat_fn(SAT_WIDTH'(mr3_ff >>> FRACTION_BITS));
         sat_im = sat_fn(SAT_WIDTH'(mi3_ff >>> FRACTION_BITS));
      end else begin
         sat_re = sat_fn(SAT_WIDTH'(as_re3_ff));
         sat_im = sat_fn(SAT_WIDTH'(as_im3_ff));
      end
      side4_in.op     = op3_ff;
      side4_in.dz     = (op3_ff == OP_DIV) && (den3_ff == '0);
      side4_in.res_re = sat_re.value;
      side4_in.res_im = sat_im.value;
      side4_in.ov     = sat_re.ov || sat_im.ov;
      nr_abs = nr3_ff[SUM_WIDTH-1] ? -nr3_ff : nr3_ff;
      ni_abs = ni3_ff[SUM_WIDTH-1] ? -ni3_ff : ni3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side4_ff   <= side4_in;
         nr_mag4_ff <= nr_abs[PROD_WIDTH-1:0];
         ni_mag4_ff <= ni_abs[PROD_WIDTH-1:0];
         nr_neg4_ff <= nr3_ff[SUM_WIDTH-1];
         ni_neg4_ff <= ni3_ff[SUM_WIDTH-1];
         den4_ff    <= den3_ff;
      end
   end

   // dividers, one per part; the finished results ride alongside
   logic [W-1:0] qr, qi;
   logic         ovr, ovi;

   cau_div u_div_re (
      .clock   (clock),
      .en      (en),
      .num_mag (nr_mag4_ff),
      .num_neg (nr_neg4_ff),
      .den     (den4_ff),
      .q_out   (qr),
      .ov_out  (ovr)
   );

   cau_div u_div_im (
      .clock   (clock),
      .en      (en),
      .num_mag (ni_mag4_ff),
      .num_neg (ni_neg4_ff),
      .den     (den4_ff),
      .q_out   (qi),
      .ov_out  (ovi)
   );

   side_type side_ff [DIV_LATENCY];
   logic     sv_ff   [DIV_LATENCY];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LATENCY; i++) begin
            sv_ff[i] <= 1'b0;
         end
      end else if (en) begin
         sv_ff[0] <= v4_ff;
         for (int i = 1; i < DIV_LATENCY; i++) begin
            sv_ff[i] <= sv_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side4_ff;
         for (int i = 1; i < DIV_LATENCY; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // output register: pick the divider result for divide items
   side_type last;
   logic            rsp_valid_ff;
   logic [W-1:0]    res_re_ff, res_im_ff, res_re_in, res_im_in;
   logic            ov_ff, dz_ff, ov_in;

   assign last = side_ff[DIV_LATENCY-1];

   always_comb begin
      res_re_in = last.res_re;
      res_im_in = last.res_im;
      ov_in     = last.ov;
      if (last.op == OP_DIV) begin
         if (last.dz) begin
            res_re_in = '0;
            res_im_in = '0;
            ov_in     = 1'b0;
         end else begin
            res_re_in = qr;
            res_im_in = qi;
            ov_in     = ovr || ovi;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= sv_ff[DIV_LATENCY-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         ov_ff     <= ov_in;
         dz_ff     <= last.dz;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_res_real       = res_re_ff;
   assign rsp_res_imag       = res_im_ff;
   assign rsp_overflow       = ov_ff;
   assign rsp_divide_by_zero = dz_ff;

endmodule

>>> rtl/core/cau_checker.sv
// Port-level checks for the complex arithmetic unit and their bind.
module cau_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [cau_pkg::DATA_WIDTH-1:0] rsp_res_real,
   input logic signed [cau_pkg::DATA_WIDTH-1:0] rsp_res_imag,
   input logic                                  rsp_overflow,
   input logic                                  rsp_divide_by_zero
);
   import cau_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_res_real) && $stable(rsp_res_imag))
      else $error("result changed while stalled");

   a_dz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |->
         rsp_res_real == '0 && rsp_res_imag == '0 && !rsp_overflow)
      else $error("zero divisor result not cleared");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output stall");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind complex_arithmetic_unit_core cau_checker u_cau_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_res_real       (rsp_res_real),
   .rsp_res_imag       (rsp_res_imag),
   .rsp_overflow       (rsp_overflow),
   .rsp_divide_by_zero (rsp_divide_by_zero)
);
